// File: rtl/cdp_pkg.sv
// ---------------------------------------------------------------------------
// cdp_pkg
// Types, constants and helper functions for the command datagram parser.
// ---------------------------------------------------------------------------
`default_nettype none

package cdp_pkg;

    localparam int IDX_W = 5;

    localparam logic [IDX_W-1:0] INDEX_MAX    = 5'd31;
    localparam logic [IDX_W-1:0] CRC_SPAN     = 5'd16;
    localparam logic [IDX_W-1:0] POS_MAGIC    = 5'd0;
    localparam logic [IDX_W-1:0] POS_TYPE     = 5'd1;
    localparam logic [IDX_W-1:0] POS_SEQ      = 5'd2;
    localparam logic [IDX_W-1:0] POS_FLAGS    = 5'd3;
    localparam logic [IDX_W-1:0] POS_BODY_LO  = 5'd4;
    localparam logic [IDX_W-1:0] POS_BODY_HI  = 5'd12;
    localparam logic [IDX_W-1:0] POS_CRC      = 5'd16;

    localparam logic [7:0] MAGIC_VALUE = 8'hA5;
    localparam logic [7:0] CRC_POLY    = 8'h07;

    localparam logic [7:0] TYPE_PAD_A    = 8'h01;
    localparam logic [7:0] TYPE_PAD_B    = 8'h02;
    localparam logic [7:0] TYPE_HELLO    = 8'h03;
    localparam logic [7:0] TYPE_LOG      = 8'h05;
    localparam logic [7:0] TYPE_USBDIAG  = 8'h06;
    localparam logic [7:0] TYPE_REBOOT   = 8'h07;
    localparam logic [7:0] TYPE_KEY_A    = 8'h08;
    localparam logic [7:0] TYPE_KEY_B    = 8'h09;
    localparam logic [7:0] TYPE_PERSONA  = 8'h0A;
    localparam logic [7:0] TYPE_FW_INFO  = 8'h0B;

    localparam logic [3:0] ACT_BAD_LENGTH  = 4'd0;
    localparam logic [3:0] ACT_BAD_MAGIC   = 4'd1;
    localparam logic [3:0] ACT_BAD_CRC     = 4'd2;
    localparam logic [3:0] ACT_UNKNOWN     = 4'd3;
    localparam logic [3:0] ACT_DISCOVER    = 4'd4;
    localparam logic [3:0] ACT_LOG         = 4'd5;
    localparam logic [3:0] ACT_USBDIAG     = 4'd6;
    localparam logic [3:0] ACT_VERSION     = 4'd7;
    localparam logic [3:0] ACT_REBOOT      = 4'd8;
    localparam logic [3:0] ACT_PERSONA     = 4'd9;
    localparam logic [3:0] ACT_PAD         = 4'd10;
    localparam logic [3:0] ACT_KEY         = 4'd11;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] source_address;
        logic [15:0] source_port;
    } in_beat_t;

    typedef struct packed {
        logic [3:0]  action;
        logic [7:0]  sequence_res;
        logic [7:0]  frame_flags;
        logic [63:0] body_low;
        logic [31:0] body_high;
        logic        peer_changed;
        logic        session_connected;
        logic [31:0] received_total;
    } result_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [3:0] classify(input logic [7:0] t);
        logic [3:0] a;
        unique case (t)
            TYPE_PAD_A, TYPE_PAD_B: a = ACT_PAD;
            TYPE_HELLO:             a = ACT_DISCOVER;
            TYPE_LOG:               a = ACT_LOG;
            TYPE_USBDIAG:           a = ACT_USBDIAG;
            TYPE_REBOOT:            a = ACT_REBOOT;
            TYPE_KEY_A, TYPE_KEY_B: a = ACT_KEY;
            TYPE_PERSONA:           a = ACT_PERSONA;
            TYPE_FW_INFO:           a = ACT_VERSION;
            default:                a = ACT_UNKNOWN;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// File: rtl/cdp_in_if.sv
// ---------------------------------------------------------------------------
// cdp_in_if
// Valid/ready channel that carries one datagram byte and its sender.
// ---------------------------------------------------------------------------
`default_nettype none

interface cdp_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] source_address;
    logic [15:0] source_port;

    modport source (
        output valid, data_byte, last_byte, source_address, source_port,
        input  ready
    );

    modport sink (
        input  valid, data_byte, last_byte, source_address, source_port,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/cdp_out_if.sv
// ---------------------------------------------------------------------------
// cdp_out_if
// Valid/ready channel that carries one parsed datagram result.
// ---------------------------------------------------------------------------
`default_nettype none

interface cdp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic [7:0]  sequence_res;
    logic [7:0]  frame_flags;
    logic [63:0] body_low;
    logic [31:0] body_high;
    logic        peer_changed;
    logic        session_connected;
    logic [31:0] received_total;

    modport source (
        output valid, action, sequence_res, frame_flags, body_low, body_high,
               peer_changed, session_connected, received_total,
        input  ready
    );

    modport sink (
        input  valid, action, sequence_res, frame_flags, body_low, body_high,
               peer_changed, session_connected, received_total,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/cdp_frame.sv
// ---------------------------------------------------------------------------
// cdp_frame
// Per-datagram capture, CRC-8 accumulation, checks and peer tracking.
// ---------------------------------------------------------------------------
`default_nettype none

module cdp_frame (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  cdp_pkg::in_beat_t      beat,
    output cdp_pkg::result_t       res
);
    import cdp_pkg::*;

    logic [IDX_W-1:0] idx_reg,   idx_next;
    logic [7:0]       crc_reg,   crc_next;
    logic [7:0]       magic_reg, magic_next;
    logic [7:0]       type_reg,  type_next;
    logic [7:0]       seq_reg,   seq_next;
    logic [7:0]       flags_reg, flags_next;
    logic [63:0]      body_lo_reg, body_lo_next;
    logic [31:0]      body_hi_reg, body_hi_next;
    logic             peer_valid_reg, peer_valid_next;
    logic [31:0]      remote_ip_reg, remote_ip_next;
    logic [15:0]      remote_udp_reg, remote_udp_next;
    logic [31:0]      count_reg, count_next;

    logic [3:0]  action;
    logic        good;
    logic        pad_or_key;
    logic        changed;
    logic [31:0] count_inc;

    assign count_inc = count_reg + 32'd1;

    always_comb
    begin
        good = 1'b0;
        priority if (idx_reg != POS_CRC)
        begin
            action = ACT_BAD_LENGTH;
        end
        else if (magic_reg != MAGIC_VALUE)
        begin
            action = ACT_BAD_MAGIC;
        end
        else if (crc_reg != beat.data_byte)
        begin
            action = ACT_BAD_CRC;
        end
        else
        begin
            action = classify(type_reg);
            good   = 1'b1;
        end

        pad_or_key = good && (action == ACT_PAD || action == ACT_KEY);
        changed    = pad_or_key && (!peer_valid_reg
                                    || remote_ip_reg != beat.source_address
                                    || remote_udp_reg != beat.source_port);

        res.action            = action;
        res.sequence_res      = good ? seq_reg     : 8'd0;
        res.frame_flags       = good ? flags_reg   : 8'd0;
        res.body_low          = good ? body_lo_reg : 64'd0;
        res.body_high         = good ? body_hi_reg : 32'd0;
        res.peer_changed      = changed;
        res.session_connected = pad_or_key & flags_reg[0];
        res.received_total    = count_inc;
    end

    always_comb
    begin
        idx_next        = idx_reg;
        crc_next        = crc_reg;
        magic_next      = magic_reg;
        type_next       = type_reg;
        seq_next        = seq_reg;
        flags_next      = flags_reg;
        body_lo_next    = body_lo_reg;
        body_hi_next    = body_hi_reg;
        peer_valid_next = peer_valid_reg;
        remote_ip_next  = remote_ip_reg;
        remote_udp_next = remote_udp_reg;
        count_next      = count_reg;

        if (step)
        begin
            if (beat.last_byte)
            begin
                idx_next     = '0;
                crc_next     = '0;
                magic_next   = '0;
                type_next    = '0;
                seq_next     = '0;
                flags_next   = '0;
                body_lo_next = '0;
                body_hi_next = '0;
                count_next   = count_inc;
                if (changed)
                begin
                    peer_valid_next = 1'b1;
                    remote_ip_next  = beat.source_address;
                    remote_udp_next = beat.source_port;
                end
            end
            else
            begin
                if (idx_reg == POS_MAGIC)
                begin
                    magic_next = beat.data_byte;
                end
                if (idx_reg == POS_TYPE)
                begin
                    type_next = beat.data_byte;
                end
                if (idx_reg == POS_SEQ)
                begin
                    seq_next = beat.data_byte;
                end
                if (idx_reg == POS_FLAGS)
                begin
                    flags_next = beat.data_byte;
                end
                for (int k = 0; k < 8; k++)
                begin
                    if (idx_reg == POS_BODY_LO + IDX_W'(k))
                    begin
                        body_lo_next[k*8 +: 8] = beat.data_byte;
                    end
                end
                for (int k = 0; k < 4; k++)
                begin
                    if (idx_reg == POS_BODY_HI + IDX_W'(k))
                    begin
                        body_hi_next[k*8 +: 8] = beat.data_byte;
                    end
                end
                if (idx_reg < CRC_SPAN)
                begin
                    crc_next = crc8_update(crc_reg, beat.data_byte);
                end
                if (idx_reg != INDEX_MAX)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            crc_reg        <= '0;
            magic_reg      <= '0;
            type_reg       <= '0;
            seq_reg        <= '0;
            flags_reg      <= '0;
            body_lo_reg    <= '0;
            body_hi_reg    <= '0;
            peer_valid_reg <= 1'b0;
            remote_ip_reg  <= '0;
            remote_udp_reg <= '0;
            count_reg      <= '0;
        end
        else
        begin
            idx_reg        <= idx_next;
            crc_reg        <= crc_next;
            magic_reg      <= magic_next;
            type_reg       <= type_next;
            seq_reg        <= seq_next;
            flags_reg      <= flags_next;
            body_lo_reg    <= body_lo_next;
            body_hi_reg    <= body_hi_next;
            peer_valid_reg <= peer_valid_next;
            remote_ip_reg  <= remote_ip_next;
            remote_udp_reg <= remote_udp_next;
            count_reg      <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/command_datagram_parser.sv
// ---------------------------------------------------------------------------
// command_datagram_parser
// Parses fixed 17-byte command datagrams, checks length, magic and CRC-8,
// classifies the command and tracks the session peer.
// ---------------------------------------------------------------------------
//  Channel   Dir  Beat contents
//  in_ch     in   data_byte, last_byte, source_address, source_port
//  out_ch    out  action, sequence_res, frame_flags, body_low, body_high,
//                 peer_changed, session_connected, received_total
//
//  One beat is accepted per cycle unless a final byte waits in the input
//  register; a beat's result, if any, goes from there to the output
//  register, with the CRC-8 update and checks as one pass between them.
//  A non-final byte advances even while a result waits; a final byte waits
//  only while the output register is full and not being read.
//  Reset clears the frame state, the peer and the datagram count.
// ---------------------------------------------------------------------------
`default_nettype none

module command_datagram_parser (
    input  wire logic clk,
    input  wire logic rst_n,
    cdp_in_if.sink    in_ch,
    cdp_out_if.source out_ch
);
    import cdp_pkg::*;

    logic      in_valid_reg;
    in_beat_t  in_beat_reg;
    logic      out_valid_reg;
    result_t   out_res_reg;
    result_t   res;
    logic      advance;
    logic      accept;

    assign advance = in_valid_reg
                     && (!in_beat_reg.last_byte || !out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign accept      = in_ch.valid && in_ch.ready;

    cdp_frame u_frame (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .beat  (in_beat_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance && in_beat_reg.last_byte)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_beat_reg.data_byte      <= in_ch.data_byte;
            in_beat_reg.last_byte      <= in_ch.last_byte;
            in_beat_reg.source_address <= in_ch.source_address;
            in_beat_reg.source_port    <= in_ch.source_port;
        end
        if (advance && in_beat_reg.last_byte)
        begin
            out_res_reg <= res;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.action            = out_res_reg.action;
    assign out_ch.sequence_res      = out_res_reg.sequence_res;
    assign out_ch.frame_flags       = out_res_reg.frame_flags;
    assign out_ch.body_low          = out_res_reg.body_low;
    assign out_ch.body_high         = out_res_reg.body_high;
    assign out_ch.peer_changed      = out_res_reg.peer_changed;
    assign out_ch.session_connected = out_res_reg.session_connected;
    assign out_ch.received_total    = out_res_reg.received_total;

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the command datagram parser. Datagrams are sent
// one beat per byte, first from a table of hand-picked frames, then as
// random frames that are mostly well formed. Every beat is run through a
// local parser model, and each result beat is checked field by field.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cdp_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          RANDOM_BEATS = 690;
    localparam int          LONG_HOLD    = 300;
    localparam int          N_DIRECTED   = 24;
    localparam int          MAX_LEN      = 40;
    localparam logic [5:0]  FRAME_BYTES  = 6'd17;
    localparam logic [31:0] HOST_A       = 32'h0A00_0002;
    localparam logic [15:0] HOST_PORT_A  = 16'd50000;
    localparam logic [31:0] HOST_B       = 32'hC0A8_0117;
    localparam logic [15:0] HOST_PORT_B  = 16'd4321;

    typedef struct packed {
        logic [5:0]  len;
        logic [7:0]  magic;
        logic [7:0]  ftype;
        logic [7:0]  seq;
        logic [7:0]  flags;
        logic [95:0] body;
        logic        crc_ok;
        logic [31:0] addr;
        logic [15:0] port;
        logic        typed;
        logic [3:0]  exp_action;
        logic [31:0] exp_total;
    } frame_row_t;

    logic clk = 1'b0;
    logic rst_n;

    cdp_in_if  in_ch();
    cdp_out_if out_ch();

    command_datagram_parser u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #4 clk = ~clk;

    frame_row_t directed_frames [N_DIRECTED] = '{
        '{6'd1, MAGIC_VALUE, TYPE_PAD_A, 8'h11, 8'h01, 96'h0, 1'b1,
          HOST_A, HOST_PORT_A, 1'b1, ACT_BAD_LENGTH, 32'd1},
        '{FRAME_BYTES, 8'h00, TYPE_PAD_A, 8'h12, 8'h01, 96'h5, 1'b1,
          HOST_A, HOST_PORT_A, 1'b1, ACT_BAD_MAGIC, 32'd2},
        '{FRAME_BYTES, MAGIC_VALUE, TYPE_PAD_A, 8'h13, 8'h01, 96'h6, 1'b0,
          HOST_A, HOST_PORT_A, 1'b1, ACT_BAD_CRC, 32'd3},
        '{6'd16, MAGIC_VALUE, TYPE_PAD_A, 8'h14, 8'h01, 96'h7, 1'b1,
          HOST_A, HOST_PORT_A, 1'b1, ACT_BAD_LENGTH, 32'd4},
        '{6'd18, MAGIC_VALUE, TYPE_PAD_A, 8'h15, 8'h01, 96'h8, 1'b1,
          HOST_A, HOST_PORT_A, 1'b1, ACT_BAD_LENGTH, 32'd5},
        '{6'd40, MAGIC_VALUE, TYPE_KEY_A, 8'h16, 8'h01, 96'h9, 1'b1,
          HOST_A, HOST_PORT_A, 1'b1, ACT_BAD_LENGTH, 32'd6},
        '{FRAME_BYTES, 8'hFF, TYPE_KEY_A, 8'h17, 8'h01, 96'hA, 1'b0,
          HOST_A, HOST_PORT_A, 1'b1, ACT_BAD_MAGIC, 32'd7},
        '{FRAME_BYTES, 8'hA4, TYPE_LOG, 8'h18, 8'h00, 96'hB, 1'b1,
          HOST_A, HOST_PORT_A, 1'b1, ACT_BAD_MAGIC, 32'd8},
        '{FRAME_BYTES, MAGIC_VALUE, TYPE_PAD_A, 8'h00, 8'h01, 96'h0, 1'b1,
          32'h0, 16'h0, 1'b0, ACT_BAD_LENGTH, 32'd0},
        '{FRAME_BYTES, MAGIC_VALUE, TYPE_PAD_B, 8'h01, 8'h00,
          96'h0123_4567_89AB_CDEF_FEDC_BA98, 1'b1,
          32'h0, 16'h0, 1'b0, ACT_BAD_LENGTH, 32'd0},
        '{FRAME_BYTES, MAGIC_VALUE, TYPE_KEY_A, 8'h42, 8'h03,
          96'hA5A5_5A5A_0F0F_F0F0_3C3C_C3C3, 1'b1,
          HOST_A, HOST_PORT_A, 1'b0, ACT_BAD_LENGTH, 32'd0},
        '{FRAME_BYTES, MAGIC_VALUE, TYPE_KEY_B, 8'hFF, 8'hFF, {96{1'b1}}, 1'b1,
          32'hFFFF_FFFF, 16'hFFFF, 1'b0, ACT_BAD_LENGTH, 32'd0},
        '{FRAME_BYTES, MAGIC_VALUE, TYPE_PAD_A, 8'h80, 8'hFE, 96'h1, 1'b1,
          32'hFFFF_FFFF, 16'hFFFF, 1'b0, ACT_BAD_LENGTH, 32'd0},
        '{FRAME_BYTES, MAGIC_VALUE, TYPE_PAD_B, 8'h7F, 8'h01, 96'h2, 1'b1,
          32'hFFFF_FFFF, 16'h0000, 1'b0, ACT_BAD_LENGTH, 32'd0},
        '{FRAME_BYTES, MAGIC_VALUE, TYPE_HELLO, 8'h20, 8'h01, 96'h3, 1'b1,
          HOST_B, HOST_PORT_B, 1'b0, ACT_BAD_LENGTH, 32'd0},
        '{FRAME_BYTES, MAGIC_VALUE, TYPE_LOG, 8'h00, 8'h00, 96'h0, 1'b1,
          HOST_B, HOST_PORT_B, 1'b0, ACT_BAD_LENGTH, 32'd0},
        '{FRAME_BYTES, MAGIC_VALUE, TYPE_USBDIAG, 8'h22, 8'h55, 96'h4, 1'b1,
          HOST_B, HOST_PORT_B, 1'b0, ACT_BAD_LENGTH, 32'd0},
        '{FRAME_BYTES, MAGIC_VALUE, TYPE_REBOOT, 8'h23, 8'hAA, 96'h5, 1'b1,
          HOST_B, HOST_PORT_B, 1'b0, ACT_BAD_LENGTH, 32'd0},
        '{FRAME_BYTES, MAGIC_VALUE, TYPE_PERSONA, 8'h24, 8'h01, 96'h6, 1'b1,
          HOST_B, HOST_PORT_B, 1'b0, ACT_BAD_LENGTH, 32'd0},
        '{FRAME_BYTES, MAGIC_VALUE, TYPE_FW_INFO, 8'h25, 8'h02, 96'h7, 1'b1,
          HOST_B, HOST_PORT_B, 1'b0, ACT_BAD_LENGTH, 32'd0},
        '{FRAME_BYTES, MAGIC_VALUE, 8'h00, 8'h26, 8'h01, 96'h8, 1'b1,
          HOST_B, HOST_PORT_B, 1'b0, ACT_BAD_LENGTH, 32'd0},
        '{FRAME_BYTES, MAGIC_VALUE, 8'h04, 8'h27, 8'h01, 96'h9, 1'b1,
          HOST_B, HOST_PORT_B, 1'b0, ACT_BAD_LENGTH, 32'd0},
        '{FRAME_BYTES, MAGIC_VALUE, 8'hFF, 8'h28, 8'h01, 96'hA, 1'b1,
          HOST_B, HOST_PORT_B, 1'b0, ACT_BAD_LENGTH, 32'd0},
        '{FRAME_BYTES, MAGIC_VALUE, 8'h0C, 8'h29, 8'h01, 96'hB, 1'b1,
          32'h0, 16'h0, 1'b0, ACT_BAD_LENGTH, 32'd0}
    };

    logic [7:0] known_types [10] = '{
        TYPE_PAD_A, TYPE_PAD_B, TYPE_HELLO, TYPE_LOG, TYPE_USBDIAG,
        TYPE_REBOOT, TYPE_KEY_A, TYPE_KEY_B, TYPE_PERSONA, TYPE_FW_INFO
    };

    logic [31:0] remote_hosts [3];
    logic [15:0] remote_udps [3];

    logic [4:0]  pos_count;
    logic [7:0]  crc_acc;
    logic [7:0]  magic_b;
    logic [7:0]  type_b;
    logic [7:0]  seq_b;
    logic [7:0]  flags_b;
    logic [63:0] body_lo;
    logic [31:0] body_hi;
    logic [7:0]  crc_rx;
    logic        peer_known;
    logic [31:0] remote_ip;
    logic [15:0] remote_udp;
    logic [31:0] datagram_total;

    result_t pending_verdicts [$];
    result_t typed_verdict;
    logic    typed_pending = 1'b0;

    int failures          = 0;
    int cycle_count       = 0;
    int beats_sent        = 0;
    int src_idle_pct      = 19;
    int sink_idle_pct     = 88;
    int hold_left         = 0;
    logic long_hold_pending = 1'b0;

    function automatic logic [7:0] crc_smbus_next(input logic [7:0] acc,
                                                  input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        repeat (8)
        begin
            c = (c << 1) ^ (c[7] ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic logic [3:0] command_action(input logic [7:0] t);
        case (t)
            TYPE_PAD_A, TYPE_PAD_B: return ACT_PAD;
            TYPE_KEY_A, TYPE_KEY_B: return ACT_KEY;
            TYPE_HELLO:             return ACT_DISCOVER;
            TYPE_LOG:               return ACT_LOG;
            TYPE_USBDIAG:           return ACT_USBDIAG;
            TYPE_REBOOT:            return ACT_REBOOT;
            TYPE_PERSONA:           return ACT_PERSONA;
            TYPE_FW_INFO:           return ACT_VERSION;
            default:                return ACT_UNKNOWN;
        endcase
    endfunction

    function void clear_capture();
        pos_count = '0;
        crc_acc   = '0;
        magic_b   = '0;
        type_b    = '0;
        seq_b     = '0;
        flags_b   = '0;
        body_lo   = '0;
        body_hi   = '0;
        crc_rx    = '0;
    endfunction

    function void parse_datagram_byte(input logic [7:0] b, input logic last,
                                      input logic [31:0] addr, input logic [15:0] port);
        result_t    r;
        logic [4:0] pos;
        pos = pos_count;
        if (pos == POS_MAGIC)
            magic_b = b;
        else if (pos == POS_TYPE)
            type_b = b;
        else if (pos == POS_SEQ)
            seq_b = b;
        else if (pos == POS_FLAGS)
            flags_b = b;
        else if (pos >= POS_BODY_LO && pos < POS_BODY_HI)
            body_lo[8*(pos - POS_BODY_LO) +: 8] = b;
        else if (pos >= POS_BODY_HI && pos < POS_CRC)
            body_hi[8*(pos - POS_BODY_HI) +: 8] = b;
        else if (pos == POS_CRC)
            crc_rx = b;
        if (pos < CRC_SPAN)
            crc_acc = crc_smbus_next(crc_acc, b);
        if (pos != INDEX_MAX)
            pos_count = pos + 5'd1;
        if (!last)
            return;

        datagram_total = datagram_total + 32'd1;
        r = '0;
        r.received_total = datagram_total;
        if (pos != POS_CRC)
            r.action = ACT_BAD_LENGTH;
        else if (magic_b != MAGIC_VALUE)
            r.action = ACT_BAD_MAGIC;
        else if (crc_acc != crc_rx)
            r.action = ACT_BAD_CRC;
        else
        begin
            r.action       = command_action(type_b);
            r.sequence_res = seq_b;
            r.frame_flags  = flags_b;
            r.body_low     = body_lo;
            r.body_high    = body_hi;
            if (r.action == ACT_PAD || r.action == ACT_KEY)
            begin
                if (!peer_known || remote_ip != addr || remote_udp != port)
                begin
                    peer_known     = 1'b1;
                    remote_ip      = addr;
                    remote_udp     = port;
                    r.peer_changed = 1'b1;
                end
                r.session_connected = flags_b[0];
            end
        end
        if (typed_pending)
        begin
            pending_verdicts.push_back(typed_verdict);
            typed_pending = 1'b0;
        end
        else
            pending_verdicts.push_back(r);
        clear_capture();
    endfunction

    function automatic frame_row_t random_frame();
        frame_row_t f;
        int         pick;
        int         slot;
        f        = '0;
        pick     = $urandom_range(99);
        f.len    = FRAME_BYTES;
        f.magic  = MAGIC_VALUE;
        f.crc_ok = 1'b1;
        f.ftype  = ($urandom_range(4) == 0) ? 8'($urandom) : known_types[$urandom_range(9)];
        f.seq    = 8'($urandom);
        f.flags  = 8'($urandom);
        f.body   = {$urandom, $urandom, $urandom};
        if (pick >= 70 && pick < 80)
            f.magic = MAGIC_VALUE ^ 8'($urandom_range(1, 255));
        else if (pick >= 80 && pick < 88)
            f.crc_ok = 1'b0;
        else if (pick >= 88)
            f.len = 6'($urandom_range(1, MAX_LEN));
        if ($urandom_range(9) < 7)
        begin
            slot   = $urandom_range(2);
            f.addr = remote_hosts[slot];
            f.port = remote_udps[slot];
        end
        else
        begin
            f.addr = $urandom;
            f.port = 16'($urandom);
        end
        return f;
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic last,
                             input logic [31:0] addr, input logic [15:0] port);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data_byte      <= b;
        in_ch.last_byte      <= last;
        in_ch.source_address <= addr;
        in_ch.source_port    <= port;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        parse_datagram_byte(b, last, addr, port);
        beats_sent++;
    endtask

    task automatic send_datagram(input frame_row_t f);
        logic [7:0] bytes [MAX_LEN];
        logic [7:0] crc;
        bytes[0] = f.magic;
        bytes[1] = f.ftype;
        bytes[2] = f.seq;
        bytes[3] = f.flags;
        for (int k = 0; k < 12; k++)
            bytes[4+k] = f.body[8*k +: 8];
        crc = '0;
        for (int k = 0; k < 16; k++)
            crc = crc_smbus_next(crc, bytes[k]);
        bytes[16] = f.crc_ok ? crc : crc ^ 8'h5A;
        for (int k = 17; k < MAX_LEN; k++)
            bytes[k] = 8'($urandom);
        if (f.typed)
        begin
            typed_verdict                = '0;
            typed_verdict.action         = f.exp_action;
            typed_verdict.received_total = f.exp_total;
            typed_pending                = 1'b1;
        end
        for (int k = 0; k < f.len; k++)
            send_beat(bytes[k], k == f.len - 1, f.addr, f.port);
    endtask

    function void check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            failures++;
        end
    endfunction

    task automatic check_verdict();
        result_t got;
        result_t want;
        got.action            = out_ch.action;
        got.sequence_res      = out_ch.sequence_res;
        got.frame_flags       = out_ch.frame_flags;
        got.body_low          = out_ch.body_low;
        got.body_high         = out_ch.body_high;
        got.peer_changed      = out_ch.peer_changed;
        got.session_connected = out_ch.session_connected;
        got.received_total    = out_ch.received_total;
        if (pending_verdicts.size() == 0)
        begin
            $display("%0t ns: unexpected result beat, expected none, actual action %h total %h",
                     $time, got.action, got.received_total);
            failures++;
        end
        else
        begin
            want = pending_verdicts.pop_front();
            check_field("action", want.action, got.action);
            check_field("sequence_res", want.sequence_res, got.sequence_res);
            check_field("frame_flags", want.frame_flags, got.frame_flags);
            check_field("body_low", want.body_low, got.body_low);
            check_field("body_high", want.body_high, got.body_high);
            check_field("peer_changed", want.peer_changed, got.peer_changed);
            check_field("session_connected", want.session_connected,
                        got.session_connected);
            check_field("received_total", want.received_total, got.received_total);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                check_verdict();
            if (long_hold_pending)
            begin
                hold_left         = LONG_HOLD;
                long_hold_pending = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial
    begin
        int random_start;
        rst_n                <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.data_byte      <= '0;
        in_ch.last_byte      <= 1'b0;
        in_ch.source_address <= '0;
        in_ch.source_port    <= '0;
        clear_capture();
        peer_known     = 1'b0;
        remote_ip      = '0;
        remote_udp     = '0;
        datagram_total = '0;
        for (int k = 0; k < 3; k++)
        begin
            remote_hosts[k] = $urandom;
            remote_udps[k]  = 16'($urandom);
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < N_DIRECTED; k++)
            send_datagram(directed_frames[k]);

        random_start = beats_sent;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 19;
                    sink_idle_pct = 88;
                end
                1:
                begin
                    src_idle_pct  = 88;
                    sink_idle_pct = 19;
                end
                default:
                begin
                    src_idle_pct      = 0;
                    sink_idle_pct     = 0;
                    long_hold_pending = 1'b1;
                end
            endcase
            while (beats_sent - random_start < (phase + 1) * RANDOM_BEATS / 3)
                send_datagram(random_frame());
        end
        in_ch.valid <= 1'b0;

        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
